// ===== sv/kls_pkg.sv =====
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants for the keyframe linear sampler
// Holds field widths, operation codes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

   localparam int TIME_W    = 32;
   localparam int VAL_W     = 32;
   localparam int IDX_W     = 6;
   localparam int COUNT_W   = 7;
   localparam int FRAC_W    = 16;
   localparam int QUOT_W    = FRAC_W + 1;
   localparam int DIV_STEPS = FRAC_W;
   localparam int MUL_STEPS = 4;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] key_time;
      logic [VAL_W-1:0]  x;
      logic [VAL_W-1:0]  y;
      logic [VAL_W-1:0]  z;
   } entry_type;

   typedef enum logic [1:0] {
      LANE_X = 2'd0,
      LANE_Y = 2'd1,
      LANE_Z = 2'd2
   } lane_type;

   typedef enum logic [1:0] {
      RES_NONE  = 2'd0,
      RES_FIRST = 2'd1,
      RES_PREV  = 2'd2,
      RES_NEXT  = 2'd3
   } res_src_type;

   typedef struct packed {
      logic        write;
      logic        start;
      logic        rd_en;
      logic        take_prev;
      logic        step;
      res_src_type res_src;
      logic        div_start;
      logic        div_step;
      logic        mul_en;
      lane_type    mul_lane;
      logic        add_en;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic single_key;
      logic t_le_first;
      logic found;
      logic span_zero;
      logic is_last;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/kls_req_if.sv =====
// ----------------------------------------------------------------------------
// kls_req_if: request channel
// Valid/ready channel carrying one write or sample item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kls_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [5:0]         key_index;
   logic [31:0]        key_time;
   logic signed [31:0] key_x;
   logic signed [31:0] key_y;
   logic signed [31:0] key_z;
   logic [31:0]        sample_time;

   modport source (
      output valid, operation, key_index, key_time, key_x, key_y, key_z, sample_time,
      input  ready
   );

   modport sink (
      input  valid, operation, key_index, key_time, key_x, key_y, key_z, sample_time,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/kls_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kls_rsp_if: response channel
// Valid/ready channel carrying one sampled vector and its segment index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kls_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [5:0]         segment_start;

   modport source (
      output valid, out_x, out_y, out_z, segment_start,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, segment_start,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/kls_datapath.sv =====
// ----------------------------------------------------------------------------
// kls_datapath: key table, segment walk, divider and interpolator
// Holds the key table memory, the key count register, the serial fraction
// divider, the shared multiplier and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kls_datapath
   import kls_pkg::*;
#(
   parameter int MAX_KEYS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output      status_type         status,
   input  wire logic               csr_we,
   input  wire logic [COUNT_W-1:0] csr_wdata,
   input  wire logic [IDX_W-1:0]   req_key_index,
   input  wire logic [TIME_W-1:0]  req_key_time,
   input  wire logic [VAL_W-1:0]   req_key_x,
   input  wire logic [VAL_W-1:0]   req_key_y,
   input  wire logic [VAL_W-1:0]   req_key_z,
   input  wire logic [TIME_W-1:0]  req_sample_time,
   output      logic signed [VAL_W-1:0] rsp_out_x,
   output      logic signed [VAL_W-1:0] rsp_out_y,
   output      logic signed [VAL_W-1:0] rsp_out_z,
   output      logic [IDX_W-1:0]   rsp_segment_start
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);
   localparam int CW = NW + 1;
   localparam int PW = VAL_W + 1 + QUOT_W + 1;

   entry_type mem [MAX_KEYS];

   logic [COUNT_W-1:0] key_count_ff;
   logic [TIME_W-1:0]  t_ff;
   logic [NW-1:0]      n_ff, n_in;
   logic [AW-1:0]      i_ff;
   entry_type          prev_ff, rd_ff;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic               wr_ok;
   entry_type          wr_entry;

   logic [TIME_W-1:0]  rem_ff, span_ff;
   logic [QUOT_W-1:0]  q_ff;
   logic [TIME_W-1:0]  d_val, span_val, rem_next;
   logic [TIME_W:0]    rem2, rem_sub;
   logic               rem_ge;

   logic [VAL_W-1:0]   mul_v0, mul_v1, add_v0;
   logic signed [VAL_W:0]   diff;
   logic signed [QUOT_W:0]  frac_s;
   logic signed [PW-1:0]    prod;
   logic [VAL_W-1:0]   p_ff;
   lane_type           p_lane_ff;
   logic [VAL_W-1:0]   sum;

   logic [VAL_W-1:0]   res_x_ff, res_y_ff, res_z_ff;
   logic [IDX_W-1:0]   res_idx_ff;
   logic [IDX_W-1:0]   idx_i, idx_next;

   logic [31:0]        count32;

   // key count and saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= COUNT_W'(1);
      end else if (csr_we) begin
         key_count_ff <= csr_wdata;
      end
   end

   always_comb begin
      count32 = 32'(key_count_ff);
      if (count32 == 32'd0) begin
         n_in = NW'(1);
      end else if (count32 > 32'(MAX_KEYS)) begin
         n_in = NW'(MAX_KEYS);
      end else begin
         n_in = NW'(count32);
      end
   end

   // key table
   assign wr_ok    = 32'(req_key_index) < 32'(MAX_KEYS);
   assign wr_addr  = AW'(req_key_index);
   assign wr_entry = '{key_time: req_key_time, x: req_key_x, y: req_key_y, z: req_key_z};

   always_comb begin
      if (cmd.start) begin
         rd_addr = '0;
      end else if (cmd.step) begin
         rd_addr = AW'(CW'(i_ff) + CW'(2));
      end else begin
         rd_addr = AW'(CW'(i_ff) + CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && wr_ok) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         t_ff <= req_sample_time;
         n_ff <= n_in;
         i_ff <= '0;
      end else if (cmd.step) begin
         i_ff <= i_ff + AW'(1);
      end
      if (cmd.take_prev) begin
         prev_ff <= rd_ff;
      end
   end

   assign status.single_key = n_ff == NW'(1);
   assign status.t_le_first = t_ff <= rd_ff.key_time;
   assign status.found      = (prev_ff.key_time <= t_ff) && (t_ff <= rd_ff.key_time);
   assign status.span_zero  = rd_ff.key_time == prev_ff.key_time;
   assign status.is_last    = (CW'(i_ff) + CW'(2)) == CW'(n_ff);

   // fraction divider, one quotient bit per cycle
   assign d_val    = t_ff - prev_ff.key_time;
   assign span_val = rd_ff.key_time - prev_ff.key_time;
   assign rem2     = {rem_ff, 1'b0};
   assign rem_sub  = rem2 - {1'b0, span_ff};
   assign rem_ge   = rem2 >= {1'b0, span_ff};
   assign rem_next = rem_ge ? rem_sub[TIME_W-1:0] : rem2[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         span_ff <= span_val;
         if (d_val >= span_val) begin
            rem_ff <= d_val - span_val;
            q_ff   <= QUOT_W'(1);
         end else begin
            rem_ff <= d_val;
            q_ff   <= '0;
         end
      end else if (cmd.div_step) begin
         rem_ff <= rem_next;
         q_ff   <= {q_ff[QUOT_W-2:0], rem_ge};
      end
   end

   // shared multiplier, one lane per cycle
   always_comb begin
      case (cmd.mul_lane)
         LANE_X: begin
            mul_v0 = prev_ff.x;
            mul_v1 = rd_ff.x;
         end
         LANE_Y: begin
            mul_v0 = prev_ff.y;
            mul_v1 = rd_ff.y;
         end
         LANE_Z: begin
            mul_v0 = prev_ff.z;
            mul_v1 = rd_ff.z;
         end
         default: begin
            mul_v0 = '0;
            mul_v1 = '0;
         end
      endcase
      case (p_lane_ff)
         LANE_X:  add_v0 = prev_ff.x;
         LANE_Y:  add_v0 = prev_ff.y;
         LANE_Z:  add_v0 = prev_ff.z;
         default: add_v0 = '0;
      endcase
   end

   assign diff   = signed'({mul_v1[VAL_W-1], mul_v1}) - signed'({mul_v0[VAL_W-1], mul_v0});
   assign frac_s = signed'({1'b0, q_ff});
   assign prod   = PW'(diff) * PW'(frac_s);
   assign sum    = add_v0 + p_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         p_ff      <= prod[FRAC_W+VAL_W-1:FRAC_W];
         p_lane_ff <= cmd.mul_lane;
      end
   end

   // result staging
   assign idx_i    = IDX_W'(i_ff);
   assign idx_next = IDX_W'(CW'(i_ff) + CW'(1));

   always_ff @(posedge clock) begin
      case (cmd.res_src)
         RES_FIRST: begin
            res_x_ff   <= rd_ff.x;
            res_y_ff   <= rd_ff.y;
            res_z_ff   <= rd_ff.z;
            res_idx_ff <= idx_i;
         end
         RES_PREV: begin
            res_x_ff   <= prev_ff.x;
            res_y_ff   <= prev_ff.y;
            res_z_ff   <= prev_ff.z;
            res_idx_ff <= idx_i;
         end
         RES_NEXT: begin
            res_x_ff   <= rd_ff.x;
            res_y_ff   <= rd_ff.y;
            res_z_ff   <= rd_ff.z;
            res_idx_ff <= idx_next;
         end
         default: begin
            if (cmd.add_en) begin
               res_idx_ff <= idx_i;
               case (p_lane_ff)
                  LANE_X:  res_x_ff <= sum;
                  LANE_Y:  res_y_ff <= sum;
                  LANE_Z:  res_z_ff <= sum;
                  default: res_x_ff <= res_x_ff;
               endcase
            end
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_out_x         <= signed'(res_x_ff);
         rsp_out_y         <= signed'(res_y_ff);
         rsp_out_z         <= signed'(res_z_ff);
         rsp_segment_start <= res_idx_ff;
      end
   end

endmodule

`default_nettype wire

// ===== sv/kls_ctrl.sv =====
// ----------------------------------------------------------------------------
// kls_ctrl: sequencing controller for the keyframe linear sampler
// Steps each sample item through the table walk, for interpolated segments
// the fraction division and three multiplies, and the response hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kls_ctrl
   import kls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_operation,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      cmd_type    cmd,
   input  wire status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_WALK,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '{res_src: RES_NONE, mul_lane: LANE_X, default: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  cmd.rd_en = 1'b1;
                  state_in  = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            if (status.single_key || status.t_le_first) begin
               cmd.res_src = RES_FIRST;
               state_in    = ST_EMIT;
            end else begin
               cmd.take_prev = 1'b1;
               cmd.rd_en     = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.found) begin
               if (status.span_zero) begin
                  cmd.res_src = RES_PREV;
                  state_in    = ST_EMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  cnt_in        = '0;
                  state_in      = ST_DIV;
               end
            end else if (status.is_last) begin
               cmd.res_src = RES_NEXT;
               state_in    = ST_EMIT;
            end else begin
               cmd.take_prev = 1'b1;
               cmd.step      = 1'b1;
               cmd.rd_en     = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_MUL: begin
            cmd.mul_en   = cnt_ff != CNT_W'(MUL_STEPS - 1);
            cmd.mul_lane = lane_type'(cnt_ff[1:0]);
            cmd.add_en   = cnt_ff != '0;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !(req_valid && req_operation == OP_SAMPLE))
      |=> state_ff == ST_IDLE)
      else $error("controller left idle without a sample item");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while held");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("response not raised after hand-off");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> cnt_ff <= CNT_W'(MUL_STEPS - 1))
      else $error("multiply step count out of range");

   a_write_idle_only: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (state_ff == ST_IDLE && req_operation == OP_WRITE))
      else $error("table write outside idle");

endmodule

`default_nettype wire

// ===== sv/keyframe_linear_sampler_top.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_sampler_top: linear keyframe interpolation over a key table
// Loads keyframes by write items and returns interpolated vectors for sample
// items.
//
// Channels: req_ch takes write items (operation 0: key_index, key_time and
// key_x/y/z) and sample items (operation 1: sample_time). rsp_ch returns
// out_x/y/z and segment_start, one item per sample item, none per write item.
// csr_we/csr_wdata set key_count; write it only while the block is idle.
// Sequencing: a write item is stored as it is accepted. A sample item answers
// with the first key when that is the only key or the sample time is at or
// before it; otherwise the walk reads one table entry per cycle from the key
// memory until it finds the segment or reaches the last key. An interpolated
// segment then passes the bit-serial fraction divider and then the single
// multiplier shared by x, y and z. A new sample item is taken only once the
// last one is handed off; write items are taken one per cycle while idle.
// Reset: key_count returns to 1, the controller idles and rsp_ch goes
// invalid; the key table is not cleared and must be written before use.
// Stall: a finished result waits in the response register while req_ch stays
// open; a further sample holds in its last step until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyframe_linear_sampler_top
   import kls_pkg::*;
#(
   parameter int MAX_KEYS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   kls_req_if.sink                 req_ch,
   kls_rsp_if.source               rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [COUNT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   kls_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .cmd           (cmd),
      .status        (status)
   );

   kls_datapath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_key_index     (req_ch.key_index),
      .req_key_time      (req_ch.key_time),
      .req_key_x         (unsigned'(req_ch.key_x)),
      .req_key_y         (unsigned'(req_ch.key_y)),
      .req_key_z         (unsigned'(req_ch.key_z)),
      .req_sample_time   (req_ch.sample_time),
      .rsp_out_x         (rsp_ch.out_x),
      .rsp_out_y         (rsp_ch.out_y),
      .rsp_out_z         (rsp_ch.out_z),
      .rsp_segment_start (rsp_ch.segment_start)
   );

endmodule

`default_nettype wire
